// ===== design/rfct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfct_pkg
// Shared types, sizes and codes for the reflection flow counter table.
// ----------------------------------------------------------------------------
package rfct_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CLASS_COUNT   = 4;

    // field widths fixed by the interface
    localparam int CLASS_W = 2;
    localparam int HOST_W  = 32;
    localparam int DELTA_W = 16;
    localparam int COUNT_W = 32;
    localparam int STAT_W  = 3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_PENDING  = 3'd0;
    localparam logic [STAT_W-1:0] ST_RESOLVED = 3'd1;
    localparam logic [STAT_W-1:0] ST_ATTACK   = 3'd2;
    localparam logic [STAT_W-1:0] ST_WARNING  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    // reset value of the attack limit
    localparam logic [COUNT_W-1:0] LOW_LIMIT_RESET = 32'hFFFF_FF9C;

    // one stored table entry
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [HOST_W-1:0]  host;
        logic [COUNT_W-1:0] tally;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan_en;
        logic calc;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== design/reflection_flow_counter_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reflection_flow_counter_table_top
// Per-host request/response counter table with attack classification.
//
//   channel   direction   handshake             payload
//   s_        in          s_valid / s_ready     s_protocol, s_ip_addr, s_delta
//   m_        out         m_valid / m_ready     m_count, m_status, m_was_new
//   cfg_      in          cfg_valid / cfg_ready cfg_low_limit
//
// Each item passes through these steps in order: taking it, reading every
// table entry through the single scan port of the entry memory, draining the
// compare stage, the add and the commit.
// Commit waits while the output register still holds an untaken result, and
// no new item is taken until that commit. Reset is synchronous, holds both
// ready outputs low and clears the valid flags at once, with no clearing pass.
// ----------------------------------------------------------------------------
module reflection_flow_counter_table_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rfct_pkg::CLASS_W-1:0]        s_protocol,
    input  wire logic [rfct_pkg::HOST_W-1:0]         s_ip_addr,
    input  wire logic signed [rfct_pkg::DELTA_W-1:0] s_delta,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [rfct_pkg::COUNT_W-1:0]      m_count,
    output logic [rfct_pkg::STAT_W-1:0]              m_status,
    output logic                                     m_was_new,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic signed [rfct_pkg::COUNT_W-1:0] cfg_low_limit
);

    rfct_pkg::cmd_t  cmd;
    rfct_pkg::stat_t stat;

    // sequencer
    rfct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table and arithmetic
    rfct_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_protocol    (s_protocol),
        .s_ip_addr     (s_ip_addr),
        .s_delta       (s_delta),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_low_limit (cfg_low_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_count       (m_count),
        .m_status      (m_status),
        .m_was_new     (m_was_new),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
`default_nettype wire

// ===== design/rfct_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfct_ctrl
// Sequencer for one item: accept, scan the table, add, commit the result.
// ----------------------------------------------------------------------------
module rfct_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire rfct_pkg::stat_t stat,
    output rfct_pkg::cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_CALC   = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_CALC;
            end
            S_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a scan lasts until the last entry has been read
    a_scan_to_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && stat.scan_last) |=> (state_reg == S_DRAIN))
        else $error("scan did not end after last entry");

    // a new item is taken only from idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (state_reg == S_IDLE))
        else $error("item taken outside idle");

    // commit only with room in the output register
    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> stat.out_free)
        else $error("commit with full output register");
`endif

endmodule
`default_nettype wire

// ===== design/rfct_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfct_datapath
// Entry memory with valid flags, match/free scan, saturating update,
// status classification and the output register.
// ----------------------------------------------------------------------------
module rfct_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // item
    input  wire logic [rfct_pkg::CLASS_W-1:0]        s_protocol,
    input  wire logic [rfct_pkg::HOST_W-1:0]         s_ip_addr,
    input  wire logic signed [rfct_pkg::DELTA_W-1:0] s_delta,
    // configuration
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic signed [rfct_pkg::COUNT_W-1:0] cfg_low_limit,
    // result
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [rfct_pkg::COUNT_W-1:0]      m_count,
    output logic [rfct_pkg::STAT_W-1:0]              m_status,
    output logic                                     m_was_new,
    // control
    input  wire rfct_pkg::cmd_t                      cmd,
    output rfct_pkg::stat_t                          stat
);

    // item registers
    logic [rfct_pkg::CLASS_W-1:0]        item_cls_reg;
    logic [rfct_pkg::HOST_W-1:0]         item_host_reg;
    logic signed [rfct_pkg::DELTA_W-1:0] item_delta_reg;
    logic                                class_ok;

    // table storage
    rfct_pkg::entry_t                          mem [rfct_pkg::TABLE_ENTRIES];
    logic [rfct_pkg::TABLE_ENTRIES-1:0]        valid_reg;
    logic [rfct_pkg::COUNT_W-1:0]              low_limit_reg;

    // scan pipeline
    logic [rfct_pkg::IDX_W-1:0]   scan_addr_reg;
    logic                         rd_pipe_reg;
    logic [rfct_pkg::IDX_W-1:0]   rd_idx_reg;
    logic                         rd_entry_valid_reg;
    rfct_pkg::entry_t             rd_data_reg;
    logic                         match;

    // scan results
    logic                         hit_found_reg;
    logic [rfct_pkg::IDX_W-1:0]   hit_idx_reg;
    logic [rfct_pkg::COUNT_W-1:0] hit_tally_reg;
    logic                         free_found_reg;
    logic [rfct_pkg::IDX_W-1:0]   free_idx_reg;

    // update
    logic                          full_reg;
    logic [rfct_pkg::COUNT_W-1:0]  cnt_reg;
    logic [rfct_pkg::COUNT_W-1:0]  base;
    logic [rfct_pkg::COUNT_W:0]    sum;
    logic [rfct_pkg::COUNT_W-1:0]  cnt_next;
    logic [rfct_pkg::STAT_W-1:0]   status;
    logic                          keep;
    logic                          mem_we;
    logic [rfct_pkg::IDX_W-1:0]    wr_idx;
    rfct_pkg::entry_t              wr_entry;

    // output register
    logic                                m_valid_reg;
    logic signed [rfct_pkg::COUNT_W-1:0] m_count_reg;
    logic [rfct_pkg::STAT_W-1:0]         m_status_reg;
    logic                                m_was_new_reg;

    assign cfg_ready = aresetn;
    assign class_ok  = (32'(item_cls_reg) < rfct_pkg::CLASS_COUNT);

    // attack limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg <= rfct_pkg::LOW_LIMIT_RESET;
        end else if (cfg_valid) begin
            low_limit_reg <= cfg_low_limit;
        end
    end

    // capture item on transfer
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_cls_reg   <= s_protocol;
            item_host_reg  <= s_ip_addr;
            item_delta_reg <= s_delta;
        end
    end

    // scan address and read pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg <= '0;
            rd_pipe_reg   <= 1'b0;
        end else begin
            rd_pipe_reg <= cmd.scan_en;
            if (cmd.start) begin
                scan_addr_reg <= '0;
            end else if (cmd.scan_en) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
        end
    end

    assign stat.scan_last = (scan_addr_reg == rfct_pkg::IDX_W'(rfct_pkg::TABLE_ENTRIES - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    // entry memory: one read port for the scan, one write port for commit
    always_ff @(posedge aclk) begin
        if (cmd.scan_en) begin
            rd_data_reg        <= mem[scan_addr_reg];
            rd_entry_valid_reg <= valid_reg[scan_addr_reg];
            rd_idx_reg         <= scan_addr_reg;
        end
        if (mem_we) begin
            mem[wr_idx] <= wr_entry;
        end
    end

    // compare stage: first match and first free slot
    assign match = rd_entry_valid_reg && (rd_data_reg.cls == item_cls_reg)
                   && (rd_data_reg.host == item_host_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.start) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (rd_pipe_reg) begin
            if (match && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= rd_idx_reg;
                hit_tally_reg <= rd_data_reg.tally;
            end
            if (!rd_entry_valid_reg && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
        end
    end

    // saturating add of delta to the old count (zero for a new host)
    always_comb begin
        base = hit_found_reg ? hit_tally_reg : '0;
        sum  = {base[rfct_pkg::COUNT_W-1], base}
               + (rfct_pkg::COUNT_W + 1)'(item_delta_reg);
        if (sum[rfct_pkg::COUNT_W] != sum[rfct_pkg::COUNT_W-1]) begin
            cnt_next = sum[rfct_pkg::COUNT_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            cnt_next = sum[rfct_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            cnt_reg  <= cnt_next;
            full_reg <= !hit_found_reg && !(class_ok && free_found_reg);
        end
    end

    // classify the new count
    always_comb begin
        if (full_reg) begin
            status = rfct_pkg::ST_FULL;
        end else if (!cnt_reg[rfct_pkg::COUNT_W-1] && (cnt_reg != '0)) begin
            status = rfct_pkg::ST_PENDING;
        end else if (cnt_reg == '0) begin
            status = rfct_pkg::ST_RESOLVED;
        end else if ($signed(cnt_reg) < $signed(low_limit_reg)) begin
            status = rfct_pkg::ST_ATTACK;
        end else begin
            status = rfct_pkg::ST_WARNING;
        end
        keep = (status == rfct_pkg::ST_PENDING) || (status == rfct_pkg::ST_WARNING);
    end

    // table write on commit
    assign wr_idx         = hit_found_reg ? hit_idx_reg : free_idx_reg;
    assign mem_we         = cmd.commit && keep;
    assign wr_entry.cls   = item_cls_reg;
    assign wr_entry.host  = item_host_reg;
    assign wr_entry.tally = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.commit && !full_reg) begin
            valid_reg[wr_idx] <= keep;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_count_reg   <= cnt_reg;
            m_status_reg  <= status;
            m_was_new_reg <= !hit_found_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_count   = m_count_reg;
    assign m_status  = m_status_reg;
    assign m_was_new = m_was_new_reg;

`ifndef NO_ASSERTIONS
    // a commit always presents a result next cycle
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("commit did not load output register");

    // a full table never touches the stored entries
    a_full_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && full_reg) |=> $stable(valid_reg))
        else $error("table changed on full status");

    // a full or rejected item always reports a new host
    a_full_is_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == rfct_pkg::ST_FULL)) |-> m_was_new_reg)
        else $error("full status on a known host");
`endif

endmodule
`default_nettype wire
